>>> hdl/vector_clock_unit_assert.svh
// Assertion macros for the vector clock unit.
// Used by the top level; no other dependencies.
// Defining NO_ASSERTIONS leaves every macro empty.
`ifndef VECTOR_CLOCK_UNIT_ASSERT_SVH
`define VECTOR_CLOCK_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define VCU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define VCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VCU_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define VCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/vcu_pkg.sv
// Package for the vector clock unit: payload types, lane control types and codes.
// Has no dependencies; used by every module of the block.
`timescale 1ns / 1ps

package vcu_pkg;

   // Sizes fixed by the item format.
   localparam int MAX_PROCESSES      = 8;
   localparam int DEFAULT_CLOCK_BITS = 32;
   localparam int REMOTE_BITS        = 32;
   localparam int COUNT_BITS         = 4;
   localparam int INDEX_BITS         = 3;
   localparam int ACTION_BITS        = 2;
   localparam int RELATION_BITS      = 2;

   localparam logic [COUNT_BITS-1:0] ACTIVE_RESET = 4'd8;

   // Item kinds.
   localparam logic [ACTION_BITS-1:0] ACTION_TICK    = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACTION_MERGE   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACTION_COMPARE = 2'd2;

   // Compare outcomes.
   localparam logic [RELATION_BITS-1:0] REL_BEFORE     = 2'd0;
   localparam logic [RELATION_BITS-1:0] REL_AFTER      = 2'd1;
   localparam logic [RELATION_BITS-1:0] REL_CONCURRENT = 2'd2;
   localparam logic [RELATION_BITS-1:0] REL_EQUAL      = 2'd3;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [INDEX_BITS-1:0]  process_index;
      logic [COUNT_BITS-1:0]  remote_count;
      logic [REMOTE_BITS-1:0] remote_clock_0;
      logic [REMOTE_BITS-1:0] remote_clock_1;
      logic [REMOTE_BITS-1:0] remote_clock_2;
      logic [REMOTE_BITS-1:0] remote_clock_3;
      logic [REMOTE_BITS-1:0] remote_clock_4;
      logic [REMOTE_BITS-1:0] remote_clock_5;
      logic [REMOTE_BITS-1:0] remote_clock_6;
      logic [REMOTE_BITS-1:0] remote_clock_7;
   } req_type;

   typedef struct packed {
      logic [RELATION_BITS-1:0] relation;
      logic                     tick_accepted;
   } rsp_type;

   // Per-lane controls decoded by the top level.
   typedef struct packed {
      logic update;    // the item is accepted this cycle
      logic tick_hit;  // a tick names this active slot
      logic merge;     // the item is a merge
      logic in_range;  // slot lies below the smaller of the two counts
   } lane_ctrl_type;

   // What one lane found for the merging stage.
   typedef struct packed {
      logic local_gt;
      logic remote_gt;
   } lane_flags_type;

endpackage

>>> hdl/vcu_lane.sv
// One process slot of the vector clock: its counter, increment, max and compare.
// Depends on vcu_pkg for the lane control and flag types.
`timescale 1ns / 1ps

module vcu_lane #(
   parameter int CLOCK_BITS = vcu_pkg::DEFAULT_CLOCK_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  vcu_pkg::lane_ctrl_type           ctrl,
   input  logic [vcu_pkg::REMOTE_BITS-1:0]  remote_clock,
   output vcu_pkg::lane_flags_type          flags
);

   logic [CLOCK_BITS-1:0] counter_ff;
   logic [CLOCK_BITS-1:0] counter_in;
   logic [CLOCK_BITS-1:0] remote_value;
   logic                  local_gt;
   logic                  remote_gt;

   // The remote counter is truncated or zero-extended to the local width.
   assign remote_value = CLOCK_BITS'(remote_clock);
   assign local_gt     = counter_ff > remote_value;
   assign remote_gt    = remote_value > counter_ff;

   // Only slots inside the shared range take part in a compare.
   assign flags.local_gt  = ctrl.in_range && local_gt;
   assign flags.remote_gt = ctrl.in_range && remote_gt;

   // A tick saturates at all ones; a merge keeps the larger value in slots of the shared range.
   always_comb begin
      counter_in = counter_ff;
      if (ctrl.update) begin
         if (ctrl.tick_hit) begin
            if (counter_ff != {CLOCK_BITS{1'b1}}) begin
               counter_in = counter_ff + CLOCK_BITS'(1);
            end
         end else if (ctrl.merge && ctrl.in_range && remote_gt) begin
            counter_in = remote_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

endmodule

>>> hdl/vcu_merge.sv
// Merging stage: combines the lane flags into the result item.
// Depends on vcu_pkg for the action and relation codes and the result type.
`timescale 1ns / 1ps

module vcu_merge #(
   parameter int PROCESSES = vcu_pkg::MAX_PROCESSES
) (
   input  logic [vcu_pkg::ACTION_BITS-1:0] action,
   input  logic [PROCESSES-1:0]            local_gt,
   input  logic [PROCESSES-1:0]            remote_gt,
   input  logic [PROCESSES-1:0]            tick_hit,
   output vcu_pkg::rsp_type                result
);

   logic local_le;
   logic remote_le;

   // The local clock is at most the remote one when no lane finds it larger.
   assign local_le  = ~|local_gt;
   assign remote_le = ~|remote_gt;

   // Classify a compare; every other kind reports before.
   // At most one lane can be hit by a tick.
   always_comb begin
      result.relation      = vcu_pkg::REL_BEFORE;
      result.tick_accepted = |tick_hit;
      case (action)
         vcu_pkg::ACTION_COMPARE: begin
            if (local_le && remote_le) begin
               result.relation = vcu_pkg::REL_EQUAL;
            end else if (local_le) begin
               result.relation = vcu_pkg::REL_BEFORE;
            end else if (remote_le) begin
               result.relation = vcu_pkg::REL_AFTER;
            end else begin
               result.relation = vcu_pkg::REL_CONCURRENT;
            end
         end
         default: begin
            result.relation = vcu_pkg::REL_BEFORE;
         end
      endcase
   end

endmodule

>>> hdl/vector_clock_unit.sv
// Top level of the vector clock unit: config register, lanes, merge and output register.
// Depends on vcu_pkg, vcu_lane, vcu_merge and vector_clock_unit_assert.svh.
//
//   channel | ports                          | direction | carries
//   --------+--------------------------------+-----------+-----------------------------
//   request | req_valid, req_ready, req_data | in        | one item (vcu_pkg::req_type)
//   result  | rsp_valid, rsp_ready, rsp_data | out       | one item (vcu_pkg::rsp_type)
//   config  | csr_valid, csr_ready, csr_data | in        | active process count
//
// All lanes compare or update their counter in parallel at the edge that accepts an item,
// and the result is loaded into the output register at that same edge.
// A new item is accepted every cycle unless the output register holds an untaken result.
// Synchronous reset clears all counters, empties the output register and sets the
// active count to eight. Configuration writes are always taken, one per cycle.
`timescale 1ns / 1ps
`include "vector_clock_unit_assert.svh"

module vector_clock_unit #(
   parameter int PROCESSES  = vcu_pkg::MAX_PROCESSES,
   parameter int CLOCK_BITS = vcu_pkg::DEFAULT_CLOCK_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  vcu_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output vcu_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vcu_pkg::COUNT_BITS-1:0]   csr_data
);

   localparam logic [vcu_pkg::COUNT_BITS-1:0] ProcCount = vcu_pkg::COUNT_BITS'(PROCESSES);

   logic [vcu_pkg::COUNT_BITS-1:0]  active_ff;
   logic [vcu_pkg::COUNT_BITS-1:0]  active_in;
   logic [vcu_pkg::COUNT_BITS-1:0]  local_count;
   logic [vcu_pkg::COUNT_BITS-1:0]  remote_count;
   logic [vcu_pkg::COUNT_BITS-1:0]  shared_count;
   logic                            req_accept;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   vcu_pkg::rsp_type                rsp_data_ff;
   vcu_pkg::rsp_type                result;
   logic [vcu_pkg::REMOTE_BITS-1:0] remote_clock [vcu_pkg::MAX_PROCESSES];
   logic [PROCESSES-1:0]            local_gt;
   logic [PROCESSES-1:0]            remote_gt;
   logic [PROCESSES-1:0]            tick_hit;

   // Configuration register: writes are taken at once.
   assign csr_ready = 1'b1;
   assign active_in = csr_valid ? csr_data : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= vcu_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // Counts above the number of slots are treated as all slots.
   assign local_count  = (active_ff > ProcCount) ? ProcCount : active_ff;
   assign remote_count = (req_data.remote_count > ProcCount) ? ProcCount
                                                              : req_data.remote_count;
   assign shared_count = (local_count < remote_count) ? local_count : remote_count;

   // The input side runs while the output register is empty or being emptied.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign remote_clock[0] = req_data.remote_clock_0;
   assign remote_clock[1] = req_data.remote_clock_1;
   assign remote_clock[2] = req_data.remote_clock_2;
   assign remote_clock[3] = req_data.remote_clock_3;
   assign remote_clock[4] = req_data.remote_clock_4;
   assign remote_clock[5] = req_data.remote_clock_5;
   assign remote_clock[6] = req_data.remote_clock_6;
   assign remote_clock[7] = req_data.remote_clock_7;

   // One lane per process slot.
   for (genvar i = 0; i < PROCESSES; i++) begin : g_lane
      vcu_pkg::lane_ctrl_type  ctrl;
      vcu_pkg::lane_flags_type flags;

      assign ctrl.update   = req_accept;
      assign ctrl.tick_hit = (req_data.action == vcu_pkg::ACTION_TICK)
                             && (req_data.process_index == vcu_pkg::INDEX_BITS'(i))
                             && (vcu_pkg::COUNT_BITS'(i) < local_count);
      assign ctrl.merge    = req_data.action == vcu_pkg::ACTION_MERGE;
      assign ctrl.in_range = vcu_pkg::COUNT_BITS'(i) < shared_count;

      vcu_lane #(
         .CLOCK_BITS (CLOCK_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .remote_clock (remote_clock[i]),
         .flags        (flags)
      );

      assign local_gt[i]  = flags.local_gt;
      assign remote_gt[i] = flags.remote_gt;
      assign tick_hit[i]  = ctrl.tick_hit;
   end

   // Combine what the lanes found into the result item.
   vcu_merge #(
      .PROCESSES (PROCESSES)
   ) u_merge (
      .action    (req_data.action),
      .local_gt  (local_gt),
      .remote_gt (remote_gt),
      .tick_hit  (tick_hit),
      .result    (result)
   );

   // Output register: loaded on acceptance, emptied when the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the result path.
   `VCU_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_valid, "accepted item gave no result")
   `VCU_ASSERT_NEXT(a_tick_before, clock, reset, req_accept && (req_data.action == vcu_pkg::ACTION_TICK), rsp_data.relation == vcu_pkg::REL_BEFORE, "tick result carries a relation")
   `VCU_ASSERT_NEXT(a_empty_equal, clock, reset, req_accept && (req_data.action == vcu_pkg::ACTION_COMPARE) && (shared_count == '0), rsp_data.relation == vcu_pkg::REL_EQUAL, "empty compare is not equal")
   `VCU_ASSERT_SAME(a_tick_only, clock, reset, rsp_valid && rsp_data.tick_accepted, rsp_data.relation == vcu_pkg::REL_BEFORE, "tick flag set on a compare result")

endmodule
